// File: rtl/core/prime_position_sums_core_macros.svh
// assertion macros for the prime position sums core
// both expect clk and arst_n in the scope of the use
`ifndef PRIME_POSITION_SUMS_CORE_MACROS_SVH
`define PRIME_POSITION_SUMS_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PPS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prime_position_sums_core: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prime_position_sums_core: next-cycle check failed");

`endif

// File: rtl/core/pps_pkg.sv
package pps_pkg;

	localparam int VALUE_BITS = 16;
	localparam int SUM_BITS   = 22;
	localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic                is_prime;
		logic                odd_position;
		logic [SUM_BITS-1:0] odd_total;
		logic [SUM_BITS-1:0] even_total;
		logic                odd_any;
		logic                even_any;
		logic                array_done;
	} result_t;

	// command from the sequencer to the remainder unit
	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [VALUE_BITS-1:0] divisor;
	} mod_cmd_t;

	// status back from the remainder unit
	typedef struct packed {
		logic done;
		logic rem_zero;
	} mod_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_ACCUM
	} state_t;

endpackage

// File: rtl/core/pps_mod_unit.sv
module pps_mod_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  pps_pkg::mod_cmd_t cmd,
	output pps_pkg::mod_res_t res
);

	logic [pps_pkg::VALUE_BITS-1:0] num_sr_q;
	logic [pps_pkg::VALUE_BITS-1:0] div_q;
	logic [pps_pkg::VALUE_BITS-1:0] rem_q;
	logic [pps_pkg::CNT_BITS-1:0]   cnt_q;
	logic                           done_q;
	logic [pps_pkg::VALUE_BITS:0]   shifted;
	logic [pps_pkg::VALUE_BITS:0]   div_ext;
	logic [pps_pkg::VALUE_BITS-1:0] rem_next;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, num_sr_q[pps_pkg::VALUE_BITS-1]};
		div_ext = {1'b0, div_q};
		if (shifted >= div_ext) begin
			rem_next = pps_pkg::VALUE_BITS'(shifted - div_ext);
		end else begin
			rem_next = pps_pkg::VALUE_BITS'(shifted);
		end
	end

	// step control, one dividend bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q <= pps_pkg::CNT_BITS'(pps_pkg::VALUE_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pps_pkg::CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_sr_q <= cmd.dividend;
			div_q    <= cmd.divisor;
			rem_q    <= '0;
		end else if (cnt_q != '0) begin
			num_sr_q <= {num_sr_q[pps_pkg::VALUE_BITS-2:0], 1'b0};
			rem_q    <= rem_next;
		end
	end

	assign res.done     = done_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

// File: rtl/core/prime_position_sums_core.sv
// prime position sums core
// input channel: item_valid / item_stall / item (value, last). an item transfers
// on a rising edge with item_valid high and item_stall low.
// output channel: res_valid / res_stall / res, one result per item, in order.
// each value is tested by trial division with divisors 2, 3, ... while d*d <= value.
// every divisor costs one bound check and 16 remainder steps of one dividend
// bit each, after which the done flag hands the remainder back. values below 4
// try no divisor, the worst 16-bit prime tries 254. one item is in work at a time.
// a finished result sits in the output register; the next item is taken while
// it waits, and only the final update of the running sums holds off until the
// output register is free again.
// reset clears parity, both totals, both flags and the output valid.
// an item with last set returns the running state to its reset value after
// its result is formed.
`include "prime_position_sums_core_macros.svh"

module prime_position_sums_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  pps_pkg::item_t  item,
	output logic            res_valid,
	input  logic            res_stall,
	output pps_pkg::result_t res
);

	pps_pkg::state_t state_q;
	pps_pkg::state_t state_next;

	logic [pps_pkg::VALUE_BITS-1:0] value_q;
	logic                           last_q;
	logic [pps_pkg::VALUE_BITS-1:0] d_q;
	logic [pps_pkg::VALUE_BITS:0]   sq_q;
	logic                           prime_q;

	logic                         parity_q;
	logic [pps_pkg::SUM_BITS-1:0] odd_acc_q;
	logic [pps_pkg::SUM_BITS-1:0] even_acc_q;
	logic                         odd_seen_q;
	logic                         even_seen_q;

	logic             res_valid_q;
	pps_pkg::result_t res_q;

	pps_pkg::mod_cmd_t mod_cmd;
	pps_pkg::mod_res_t mod_res;

	logic item_take;
	logic out_free;
	logic below_two;
	logic past_bound;
	logic check_prime;
	logic check_start;
	logic div_found;
	logic div_next;
	logic accum_fire;

	logic [pps_pkg::SUM_BITS:0]   sum_ext;
	logic [pps_pkg::SUM_BITS-1:0] acc_sel;
	logic [pps_pkg::SUM_BITS-1:0] acc_new;

	pps_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mod_cmd),
		.res    (mod_res)
	);

	// conditions of the trial loop
	assign below_two  = (value_q < pps_pkg::VALUE_BITS'(2));
	assign past_bound = (sq_q > {1'b0, value_q});
	assign out_free   = !res_valid_q || !res_stall;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_next = pps_pkg::ST_CHECK;
				end
			end
			pps_pkg::ST_CHECK: begin
				if (below_two || past_bound) begin
					state_next = pps_pkg::ST_ACCUM;
				end else begin
					state_next = pps_pkg::ST_DIV;
				end
			end
			pps_pkg::ST_DIV: begin
				if (mod_res.done) begin
					if (mod_res.rem_zero) begin
						state_next = pps_pkg::ST_ACCUM;
					end else begin
						state_next = pps_pkg::ST_CHECK;
					end
				end
			end
			pps_pkg::ST_ACCUM: begin
				if (out_free) begin
					state_next = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = pps_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		item_stall  = 1'b1;
		check_prime = 1'b0;
		check_start = 1'b0;
		div_found   = 1'b0;
		div_next    = 1'b0;
		accum_fire  = 1'b0;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				item_stall = 1'b0;
			end
			pps_pkg::ST_CHECK: begin
				check_prime = !below_two && past_bound;
				check_start = !below_two && !past_bound;
			end
			pps_pkg::ST_DIV: begin
				div_found = mod_res.done && mod_res.rem_zero;
				div_next  = mod_res.done && !mod_res.rem_zero;
			end
			pps_pkg::ST_ACCUM: begin
				accum_fire = out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	assign item_take = item_valid && !item_stall;

	assign mod_cmd.start    = check_start;
	assign mod_cmd.dividend = value_q;
	assign mod_cmd.divisor  = d_q;

	// saturating add of the value into the total of this position's parity
	always_comb begin
		acc_sel = parity_q ? odd_acc_q : even_acc_q;
		sum_ext = {1'b0, acc_sel}
			+ (pps_pkg::SUM_BITS + 1)'(value_q);
		if (sum_ext[pps_pkg::SUM_BITS]) begin
			acc_new = '1;
		end else begin
			acc_new = sum_ext[pps_pkg::SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// item capture and divisor walk; sq_q tracks d_q squared
	always_ff @(posedge clk) begin
		if (item_take) begin
			value_q <= item.value;
			last_q  <= item.last;
			d_q     <= pps_pkg::VALUE_BITS'(2);
			sq_q    <= (pps_pkg::VALUE_BITS + 1)'(4);
			prime_q <= 1'b0;
		end else begin
			if (check_prime) begin
				prime_q <= 1'b1;
			end
			if (div_found) begin
				prime_q <= 1'b0;
			end
			if (div_next) begin
				d_q  <= d_q + 1'b1;
				sq_q <= sq_q + {d_q, 1'b1};
			end
		end
	end

	// running state per array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			odd_acc_q   <= '0;
			even_acc_q  <= '0;
			odd_seen_q  <= 1'b0;
			even_seen_q <= 1'b0;
		end else if (accum_fire) begin
			if (last_q) begin
				parity_q    <= 1'b0;
				odd_acc_q   <= '0;
				even_acc_q  <= '0;
				odd_seen_q  <= 1'b0;
				even_seen_q <= 1'b0;
			end else begin
				parity_q <= !parity_q;
				if (prime_q && parity_q) begin
					odd_acc_q  <= acc_new;
					odd_seen_q <= 1'b1;
				end
				if (prime_q && !parity_q) begin
					even_acc_q  <= acc_new;
					even_seen_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accum_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accum_fire) begin
			res_q.is_prime     <= prime_q;
			res_q.odd_position <= parity_q;
			res_q.odd_total    <= (prime_q && parity_q) ? acc_new : odd_acc_q;
			res_q.even_total   <= (prime_q && !parity_q) ? acc_new : even_acc_q;
			res_q.odd_any      <= odd_seen_q || (prime_q && parity_q);
			res_q.even_any     <= even_seen_q || (prime_q && !parity_q);
			res_q.array_done   <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`PPS_ASSERT_NEXT(a_take_to_check, item_take, state_q == pps_pkg::ST_CHECK)
	`PPS_ASSERT_SAME(a_done_in_div, mod_res.done, state_q == pps_pkg::ST_DIV)
	`PPS_ASSERT_SAME(a_prime_ge_two, accum_fire && prime_q, !below_two)
	`PPS_ASSERT_SAME(a_rise_from_accum, $rose(res_valid_q),
		$past(state_q) == pps_pkg::ST_ACCUM)

endmodule

// File: dv/prime_sums_checker.sv
module prime_sums_checker
	import pps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    res_valid,
	input  logic    res_stall,
	input  result_t res,
	output int      errors,
	output int      outstanding,
	output int      primes_found
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [SUM_BITS-1:0] SUM_CEIL = '1;

	// predictions waiting for their result transfer, oldest first
	result_t expected_results[$];

	// running array state as the block should hold it
	logic                next_is_odd = 1'b0;
	logic [SUM_BITS-1:0] odd_sum     = '0;
	logic [SUM_BITS-1:0] even_sum    = '0;
	logic                odd_hit     = 1'b0;
	logic                even_hit    = 1'b0;

	// counters handed to the top
	int error_count = 0;
	int pending     = 0;
	int prime_count = 0;

	assign errors       = error_count;
	assign outstanding  = pending;
	assign primes_found = prime_count;

	// trial division, divisors from 2 while d*d stays within n
	function automatic logic prime_by_trial(logic [VALUE_BITS-1:0] n);
		int unsigned d;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// add and clamp at the top of the total range
	function automatic logic [SUM_BITS-1:0] sat_sum(logic [SUM_BITS-1:0] acc,
			logic [VALUE_BITS-1:0] v);
		logic [SUM_BITS:0] s;
		s = (SUM_BITS + 1)'(acc) + (SUM_BITS + 1)'(v);
		return (s > (SUM_BITS + 1)'(SUM_CEIL)) ? SUM_CEIL : s[SUM_BITS-1:0];
	endfunction

	task automatic compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		logic    prime;
		if (!arst_n) begin
			expected_results.delete();
			next_is_odd = 1'b0;
			odd_sum     = '0;
			even_sum    = '0;
			odd_hit     = 1'b0;
			even_hit    = 1'b0;
		end else begin
			// result transfer: check against the oldest prediction
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %h", $time, res);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("is_prime", want.is_prime, res.is_prime);
					compare_field("odd_position", want.odd_position, res.odd_position);
					compare_field("odd_total", want.odd_total, res.odd_total);
					compare_field("even_total", want.even_total, res.even_total);
					compare_field("odd_any", want.odd_any, res.odd_any);
					compare_field("even_any", want.even_any, res.even_any);
					compare_field("array_done", want.array_done, res.array_done);
				end
			end
			// item transfer: update running sums and queue the prediction
			if (item_valid && !item_stall) begin
				prime = prime_by_trial(item.value);
				if (prime) begin
					prime_count++;
					if (next_is_odd) begin
						odd_sum = sat_sum(odd_sum, item.value);
						odd_hit = 1'b1;
					end else begin
						even_sum = sat_sum(even_sum, item.value);
						even_hit = 1'b1;
					end
				end
				want.is_prime     = prime;
				want.odd_position = next_is_odd;
				want.odd_total    = odd_sum;
				want.even_total   = even_sum;
				want.odd_any      = odd_hit;
				want.even_any     = even_hit;
				want.array_done   = item.last;
				expected_results.push_back(want);
				// end of array clears everything
				if (item.last) begin
					next_is_odd = 1'b0;
					odd_sum     = '0;
					even_sum    = '0;
					odd_hit     = 1'b0;
					even_hit    = 1'b0;
				end else begin
					next_is_odd = !next_is_odd;
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pps_pkg::*;

	// room for a few hundred items at the worst per-item cost, several times over
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int DRAIN_CYCLES = 5000;
	localparam int RANDOM_ITEMS = 100;
	localparam int SAT_LEN      = 132;

	logic    clk;
	logic    arst_n     = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item       = '0;
	logic    res_valid;
	logic    res_stall  = 1'b0;
	result_t res;

	int errors;
	int outstanding;
	int primes_found;
	int sent   = 0;
	int arrays = 0;
	int cycles = 0;
	bit calm   = 1'b0;

	prime_position_sums_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	prime_sums_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.errors       (errors),
		.outstanding  (outstanding),
		.primes_found (primes_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results pending", cycles,
				outstanding);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: quiet stretches and stall bursts
	initial begin
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 2) == 0) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// one item transfer, with an optional idle burst ahead of it
	task automatic send_item(logic [VALUE_BITS-1:0] v, logic l);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{value: v, last: l};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent++;
		if (l)
			arrays++;
	endtask

	// hold off until every queued result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// mostly small numbers, where primes are dense, plus full-range and top-end values
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return VALUE_BITS'($urandom_range(0, 300));
		if (sel < 8)
			return VALUE_BITS'($urandom);
		if (sel == 8)
			return VALUE_BITS'($urandom_range(65000, 65535));
		return VALUE_BITS'($urandom_range(0, 3));
	endfunction

	initial begin : stimulus
		int i;
		int len;
		int rand_sent;
		rand_sent = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, one, smallest primes, square boundary, top of range
		send_item(16'd0, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd2, 1'b0);
		send_item(16'd3, 1'b0);
		send_item(16'd4, 1'b0);
		send_item(16'd9, 1'b0);
		send_item(16'd65521, 1'b0);
		send_item(16'd65535, 1'b1);
		// single-item array holding a prime
		send_item(16'd2, 1'b1);
		// array with no prime at all
		send_item(16'd0, 1'b0);
		send_item(16'd1, 1'b1);
		// large prime at an odd position, msb-only value, prime squares
		send_item(16'd4, 1'b0);
		send_item(16'd65521, 1'b0);
		send_item(16'd32768, 1'b0);
		send_item(16'd25, 1'b0);
		send_item(16'd49, 1'b0);
		send_item(16'd7, 1'b1);
		// single non-prime, then an array closing on an odd position
		send_item(16'd1, 1'b1);
		send_item(16'd3, 1'b0);
		send_item(16'd5, 1'b1);

		drain_results();

		// random arrays, mostly short
		while (rand_sent < RANDOM_ITEMS) begin
			len = $urandom_range(1, 12);
			for (i = 0; i < len; i++) begin
				send_item(pick_value(), i == len - 1);
				rand_sent++;
			end
		end

		// long array of large primes: driven into saturation on both totals
		for (i = 0; i < SAT_LEN; i++)
			send_item(($urandom_range(0, 1) != 0) ? 16'd65521 : 16'd65519, i == SAT_LEN - 1);

		// closing stretch with no idling on either side
		calm = 1'b1;
		len  = $urandom_range(8, 16);
		for (i = 0; i < len; i++)
			send_item(pick_value(), i == len - 1);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items in %0d arrays, %0d primes; both totals driven into saturation",
			sent, arrays, primes_found);
		$display("directed edge values, random short arrays, stall and idle bursts on both sides");
		if (errors == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
